/* rtl/nearest_peak_crystal_lookup_macros.svh */
// ----------------------------------------------------------------------------
// nearest_peak_crystal_lookup_macros
// Assertion macros used by the crystal lookup RTL.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PEAK_CRYSTAL_LOOKUP_MACROS_SVH
`define NEAREST_PEAK_CRYSTAL_LOOKUP_MACROS_SVH

// check a property on every clock edge outside reset
`define NPCL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a consequent in the cycle after a trigger
`define NPCL_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* rtl/npcl_pkg.sv */
// ----------------------------------------------------------------------------
// npcl_pkg
// Widths, function codes and status codes of the crystal lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package npcl_pkg;

   localparam int NUM_PEAKS_DEF  = 64;
   localparam int COORD_BITS_DEF = 16;

   localparam int INDEX_BITS   = 6;
   localparam int CRYSTAL_BITS = 6;
   localparam int STATUS_BITS  = 2;

   localparam logic FUNC_LOAD     = 1'b0;
   localparam logic FUNC_CLASSIFY = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_FOUND = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NONE  = 2'd2;

endpackage

`default_nettype wire

/* rtl/npcl_if.sv */
// ----------------------------------------------------------------------------
// npcl_if
// Valid/ready channels of the crystal lookup: request and response.
// ----------------------------------------------------------------------------
`default_nettype none

interface npcl_req_if #(
   parameter int COORD_BITS = npcl_pkg::COORD_BITS_DEF
);
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic [npcl_pkg::INDEX_BITS-1:0]     peak_index;
   logic signed [COORD_BITS-1:0]        coord_x;
   logic signed [COORD_BITS-1:0]        coord_y;

   modport source (output valid, func, peak_index, coord_x, coord_y, input ready);
   modport sink   (input valid, func, peak_index, coord_x, coord_y, output ready);
endinterface

interface npcl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [npcl_pkg::CRYSTAL_BITS-1:0]   crystal;
   logic [npcl_pkg::STATUS_BITS-1:0]    status;

   modport source (output valid, crystal, status, input ready);
   modport sink   (input valid, crystal, status, output ready);
endinterface

`default_nettype wire

/* rtl/nearest_peak_crystal_lookup.sv */
// ----------------------------------------------------------------------------
// nearest_peak_crystal_lookup
// Flood map crystal identification: a peak table is loaded entry by entry,
// and a classify item returns the index of the nearest loaded peak.
//
//   channel   dir   handshake          payload
//   req       in    valid / ready      func, peak_index, coord_x, coord_y
//   rsp       out   valid / ready      crystal, status
//
// A load gives no response. An out of range classify goes straight to the
// done state; an in range classify scans one peak per cycle into a three
// stage distance pipeline (difference, square, add and compare), drains it
// and then enters done. Done raises the response once the output is free.
// The input opens again in the cycle the response is raised.
// Reset clears the valid bits at once; a stalled response holds, loads go in.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_peak_crystal_lookup_macros.svh"

module nearest_peak_crystal_lookup #(
   parameter int NUM_PEAKS  = npcl_pkg::NUM_PEAKS_DEF,
   parameter int COORD_BITS = npcl_pkg::COORD_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   npcl_req_if.sink     req,
   npcl_rsp_if.source   rsp
);
   localparam int ADDR_BITS = (NUM_PEAKS > 1) ? $clog2(NUM_PEAKS) : 1;
   localparam int RAM_BITS  = 2 * COORD_BITS;
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int SUM_BITS  = SQ_BITS + 1;
   localparam int DIST_BITS = (SUM_BITS > 64) ? 64 : SUM_BITS;

   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(NUM_PEAKS - 1);
   localparam logic signed [COORD_BITS-1:0] POS_ONE = {2'b01, {(COORD_BITS-2){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] NEG_ONE = {2'b11, {(COORD_BITS-2){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [NUM_PEAKS-1:0]  valid_ff, valid_in;
   logic [ADDR_BITS-1:0]  scan_k_ff, scan_k_in;
   logic signed [COORD_BITS-1:0] evx_ff, evx_in, evy_ff, evy_in;
   logic                  range_ff, range_in;

   logic                  rd_live_ff, rd_live_in, rd_hit_ff, rd_hit_in;
   logic [ADDR_BITS-1:0]  rd_idx_ff, rd_idx_in;

   logic                  ad_live_ff, ad_live_in;
   logic [COORD_BITS-1:0] adx_ff, adx_in, ady_ff, ady_in;
   logic [ADDR_BITS-1:0]  ad_idx_ff, ad_idx_in;

   logic                  sq_live_ff, sq_live_in;
   logic [SQ_BITS-1:0]    sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic [ADDR_BITS-1:0]  sq_idx_ff, sq_idx_in;

   logic                  have_ff, have_in;
   logic [DIST_BITS-1:0]  best_ff, best_in;
   logic [ADDR_BITS-1:0]  best_idx_ff, best_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [npcl_pkg::CRYSTAL_BITS-1:0] crystal_ff, crystal_in;
   logic [npcl_pkg::STATUS_BITS-1:0]  status_ff, status_in;

   logic                  ram_we, ram_re;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [RAM_BITS-1:0]   ram_wdata, ram_rdata;

   logic                  accept, rsp_free, load_ok, out_range;
   logic signed [COORD_BITS-1:0] px, py;
   logic [COORD_BITS:0]   dx, dy, ndx, ndy;
   logic [SUM_BITS-1:0]   sum;
   logic                  sat;
   logic [DIST_BITS-1:0]  dist_sq;

   npcl_ram #(
      .WIDTH (RAM_BITS),
      .DEPTH (NUM_PEAKS)
   ) u_peak_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (scan_k_ff),
      .rd_data (ram_rdata)
   );

   assign req.ready   = (state_ff == ST_IDLE);
   assign accept      = req.valid && req.ready;
   assign rsp_free    = !rsp_valid_ff || rsp.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.crystal = crystal_ff;
   assign rsp.status  = status_ff;

   assign load_ok   = int'(req.peak_index) < NUM_PEAKS;
   assign out_range = (req.coord_x > POS_ONE) || (req.coord_x < NEG_ONE) ||
                      (req.coord_y > POS_ONE) || (req.coord_y < NEG_ONE);
   assign ram_waddr = ADDR_BITS'(req.peak_index);
   assign ram_wdata = {req.coord_x, req.coord_y};

   assign px  = ram_rdata[RAM_BITS-1:COORD_BITS];
   assign py  = ram_rdata[COORD_BITS-1:0];
   assign dx  = {px[COORD_BITS-1], px} - {evx_ff[COORD_BITS-1], evx_ff};
   assign dy  = {py[COORD_BITS-1], py} - {evy_ff[COORD_BITS-1], evy_ff};
   assign ndx = -dx;
   assign ndy = -dy;

   assign sum     = SUM_BITS'(sqa_ff) + SUM_BITS'(sqb_ff);
   assign sat     = (SUM_BITS > DIST_BITS) && (|(sum >> DIST_BITS));
   assign dist_sq = sat ? '1 : sum[DIST_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      scan_k_in    = scan_k_ff;
      evx_in       = evx_ff;
      evy_in       = evy_ff;
      range_in     = range_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      crystal_in   = crystal_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      // distance pipeline
      rd_live_in = 1'b0;
      rd_hit_in  = valid_ff[scan_k_ff];
      rd_idx_in  = scan_k_ff;
      ad_live_in = rd_live_ff && rd_hit_ff;
      adx_in     = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      ady_in     = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      ad_idx_in  = rd_idx_ff;
      sq_live_in = ad_live_ff;
      sqa_in     = SQ_BITS'(adx_ff) * SQ_BITS'(adx_ff);
      sqb_in     = SQ_BITS'(ady_ff) * SQ_BITS'(ady_ff);
      sq_idx_in  = ad_idx_ff;

      if (sq_live_ff && (!have_ff || (dist_sq < best_ff))) begin
         have_in     = 1'b1;
         best_in     = dist_sq;
         best_idx_in = sq_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.func == npcl_pkg::FUNC_LOAD) begin
                  if (load_ok) begin
                     ram_we              = 1'b1;
                     valid_in[ram_waddr] = 1'b1;
                  end
               end else begin
                  evx_in    = req.coord_x;
                  evy_in    = req.coord_y;
                  range_in  = out_range;
                  have_in   = 1'b0;
                  scan_k_in = '0;
                  state_in  = out_range ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ram_re     = 1'b1;
            rd_live_in = 1'b1;
            scan_k_in  = scan_k_ff + 1'b1;
            if (scan_k_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_live_ff && !ad_live_ff && !sq_live_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (range_ff) begin
                  crystal_in = '0;
                  status_in  = npcl_pkg::STATUS_RANGE;
               end else if (have_ff) begin
                  crystal_in = npcl_pkg::CRYSTAL_BITS'(best_idx_ff);
                  status_in  = npcl_pkg::STATUS_FOUND;
               end else begin
                  crystal_in = '0;
                  status_in  = npcl_pkg::STATUS_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rd_live_ff   <= 1'b0;
         ad_live_ff   <= 1'b0;
         sq_live_ff   <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_live_ff   <= rd_live_in;
         ad_live_ff   <= ad_live_in;
         sq_live_ff   <= sq_live_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_k_ff   <= scan_k_in;
      evx_ff      <= evx_in;
      evy_ff      <= evy_in;
      range_ff    <= range_in;
      rd_hit_ff   <= rd_hit_in;
      rd_idx_ff   <= rd_idx_in;
      adx_ff      <= adx_in;
      ady_ff      <= ady_in;
      ad_idx_ff   <= ad_idx_in;
      sqa_ff      <= sqa_in;
      sqb_ff      <= sqb_in;
      sq_idx_ff   <= sq_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      crystal_ff  <= crystal_in;
      status_ff   <= status_in;
   end

   `NPCL_ASSERT(a_idle_pipe_empty, clock, reset,
      (state_ff == ST_IDLE) |-> (!rd_live_ff && !ad_live_ff && !sq_live_ff),
      "distance pipeline busy while idle")
   `NPCL_ASSERT(a_rsp_from_done, clock, reset,
      $rose(rsp.valid) |-> ($past(state_ff) == ST_DONE),
      "response raised outside the done state")
   `NPCL_ASSERT(a_crystal_zero, clock, reset,
      (rsp.valid && (rsp.status != npcl_pkg::STATUS_FOUND)) |-> (rsp.crystal == '0),
      "nonzero crystal on a response without a match")
   `NPCL_ASSERT_NEXT(a_range_done, clock, reset,
      (accept && (req.func == npcl_pkg::FUNC_CLASSIFY) && out_range),
      (state_ff == ST_DONE && range_ff),
      "out of range item did not go straight to done")

endmodule

`default_nettype wire

/* rtl/npcl_ram.sv */
// ----------------------------------------------------------------------------
// npcl_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npcl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_peak_crystal_lookup. Peak loads and
// classify items go in over the request channel; a scoreboard keeps its own
// copy of the peak table and predicts each response from it. Both channels
// idle at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import npcl_pkg::*;

   localparam int CB        = COORD_BITS_DEF;
   localparam int PEAKS     = NUM_PEAKS_DEF;
   localparam int ONE       = 1 << (CB - 2);
   localparam int N_RANDOM  = 1930;
   localparam int HOLD_CYC  = 400;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   typedef struct packed {
      logic [CRYSTAL_BITS-1:0] crystal;
      logic [STATUS_BITS-1:0]  status;
   } crystal_result_type;

   class crystal_scoreboard;
      coord_type          peak_x [PEAKS];
      coord_type          peak_y [PEAKS];
      bit                 loaded [PEAKS];
      crystal_result_type expected_crystals [$];
      int unsigned        mismatches;
      int unsigned        n_loads;
      int unsigned        n_found;
      int unsigned        n_range;
      int unsigned        n_none;

      function new();
         foreach (loaded[k]) begin
            loaded[k] = 1'b0;
            peak_x[k] = '0;
            peak_y[k] = '0;
         end
         mismatches = 0;
         n_loads    = 0;
         n_found    = 0;
         n_range    = 0;
         n_none     = 0;
      endfunction

      function crystal_result_type nearest_peak(coord_type x, coord_type y);
         crystal_result_type r;
         bit                 have;
         longint             dx;
         longint             dy;
         longint unsigned    d;
         longint unsigned    best;
         have = 1'b0;
         best = '0;
         r.crystal = '0;
         r.status  = STATUS_NONE;
         if (int'(x) > ONE || int'(x) < -ONE || int'(y) > ONE || int'(y) < -ONE) begin
            r.status = STATUS_RANGE;
            return r;
         end
         for (int k = 0; k < PEAKS; k++) begin
            if (!loaded[k]) continue;
            dx = longint'(peak_x[k]) - longint'(x);
            dy = longint'(peak_y[k]) - longint'(y);
            d  = longint'(dx * dx) + longint'(dy * dy);
            if (!have || d < best) begin
               have      = 1'b1;
               best      = d;
               r.crystal = k[CRYSTAL_BITS-1:0];
               r.status  = STATUS_FOUND;
            end
         end
         return r;
      endfunction

      function void take_request(logic func, index_type idx, coord_type x, coord_type y);
         crystal_result_type r;
         if (func == FUNC_LOAD) begin
            if (int'(idx) < PEAKS) begin
               peak_x[idx] = x;
               peak_y[idx] = y;
               loaded[idx] = 1'b1;
            end
            n_loads++;
         end else begin
            r = nearest_peak(x, y);
            case (r.status)
               STATUS_FOUND: n_found++;
               STATUS_RANGE: n_range++;
               default:      n_none++;
            endcase
            expected_crystals.push_back(r);
         end
      endfunction

      function void log_mismatch(string what, crystal_result_type want,
                                 crystal_result_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s: expected crystal %0d status %0d, got crystal %0d status %0d",
                     $time, what, want.crystal, want.status, got.crystal, got.status);
      endfunction

      function void check_result(logic [CRYSTAL_BITS-1:0] crystal,
                                 logic [STATUS_BITS-1:0] status);
         crystal_result_type want;
         crystal_result_type got;
         got.crystal = crystal;
         got.status  = status;
         if (expected_crystals.size() == 0) begin
            want = '0;
            log_mismatch("response with nothing pending", want, got);
            return;
         end
         want = expected_crystals.pop_front();
         if (got.crystal !== want.crystal || got.status !== want.status)
            log_mismatch("response mismatch", want, got);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic quiet;
   logic hold_off;
   int   n_sent;

   crystal_scoreboard sb;

   npcl_req_if #(.COORD_BITS(CB)) req_ch ();
   npcl_rsp_if                    rsp_ch ();

   nearest_peak_crystal_lookup #(
      .NUM_PEAKS  (PEAKS),
      .COORD_BITS (CB)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !hold_off && (quiet || $urandom_range(0, 99) >= 9);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.crystal, rsp_ch.status);
         if (req_ch.valid && req_ch.ready)
            sb.take_request(req_ch.func, req_ch.peak_index, req_ch.coord_x, req_ch.coord_y);
      end
   end

   // hold the response side off once, while requests keep coming
   initial begin
      hold_off = 1'b0;
      wait (n_sent >= 1300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYC) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #2000000;
      $display("FAIL nearest_peak_crystal_lookup");
      $finish;
   end

   task automatic send_item(logic func, index_type idx, coord_type x, coord_type y);
      while (!quiet && $urandom_range(0, 99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= func;
      req_ch.peak_index <= idx;
      req_ch.coord_x    <= x;
      req_ch.coord_y    <= y;
      do @(posedge clock); while (!req_ch.ready);
      n_sent++;
   endtask

   function automatic coord_type coord_in_range();
      return coord_type'(int'($urandom_range(0, 2 * ONE)) - ONE);
   endfunction

   function automatic coord_type coord_any();
      return coord_type'($urandom);
   endfunction

   function automatic coord_type coord_edge();
      case ($urandom_range(0, 5))
         0:       return coord_type'(ONE);
         1:       return coord_type'(-ONE);
         2:       return coord_type'(ONE + 1);
         3:       return coord_type'(-ONE - 1);
         4:       return {1'b0, {(CB-1){1'b1}}};
         default: return {1'b1, {(CB-1){1'b0}}};
      endcase
   endfunction

   task automatic random_item();
      index_type idx;
      index_type k;
      coord_type x;
      coord_type y;
      int        pick;
      idx  = index_type'($urandom);
      k    = index_type'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         if ($urandom_range(0, 9) == 0) begin
            x = coord_any();
            y = coord_any();
         end else if ($urandom_range(0, 9) == 0 && sb.loaded[k]) begin
            x = sb.peak_x[k];
            y = sb.peak_y[k];
         end else begin
            x = coord_in_range();
            y = coord_in_range();
         end
         send_item(FUNC_LOAD, idx, x, y);
      end else begin
         if (pick < 45 && sb.loaded[k]) begin
            x = sb.peak_x[k] + coord_type'(int'($urandom_range(0, 64)) - 32);
            y = sb.peak_y[k] + coord_type'(int'($urandom_range(0, 64)) - 32);
         end else if (pick < 85) begin
            x = coord_in_range();
            y = coord_in_range();
         end else if (pick < 93) begin
            x = coord_any();
            y = coord_any();
         end else begin
            x = ($urandom_range(0, 1) != 0) ? coord_edge() : coord_in_range();
            y = ($urandom_range(0, 1) != 0) ? coord_edge() : coord_in_range();
         end
         send_item(FUNC_CLASSIFY, idx, x, y);
      end
   endtask

   initial begin
      sb                = new();
      clock             = 1'b0;
      reset             = 1'b1;
      quiet             = 1'b0;
      n_sent            = 0;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_LOAD;
      req_ch.peak_index = '0;
      req_ch.coord_x    = '0;
      req_ch.coord_y    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty table, then extremes, exact edges, ties and overwrite
      send_item(FUNC_CLASSIFY, 6'd0,  16'sd0, 16'sd0);
      send_item(FUNC_CLASSIFY, 6'd63, 16'sd32767, 16'sd0);
      send_item(FUNC_LOAD,     6'd63, 16'sh8000, 16'sh8000);
      send_item(FUNC_LOAD,     6'd0,  16'sd32767, 16'sd32767);
      send_item(FUNC_CLASSIFY, 6'd0,  16'sd16384, 16'sd16384);
      send_item(FUNC_CLASSIFY, 6'd21, -16'sd16384, -16'sd16384);
      send_item(FUNC_LOAD,     6'd9,  16'sd0, 16'sd0);
      send_item(FUNC_LOAD,     6'd5,  16'sd0, 16'sd0);
      send_item(FUNC_CLASSIFY, 6'd63, 16'sd0, 16'sd0);
      send_item(FUNC_CLASSIFY, 6'd0,  16'sd16384, -16'sd16384);
      send_item(FUNC_CLASSIFY, 6'd0,  -16'sd16384, 16'sd16384);
      send_item(FUNC_CLASSIFY, 6'd0,  16'sd16385, 16'sd0);
      send_item(FUNC_CLASSIFY, 6'd0,  -16'sd16385, 16'sd0);
      send_item(FUNC_CLASSIFY, 6'd0,  16'sd0, 16'sd16385);
      send_item(FUNC_CLASSIFY, 6'd0,  16'sd0, -16'sd16385);
      send_item(FUNC_CLASSIFY, 6'd0,  16'sh8000, 16'sh8000);
      send_item(FUNC_CLASSIFY, 6'd0,  16'sd32767, 16'sd32767);
      send_item(FUNC_LOAD,     6'd5,  16'sd100, -16'sd100);
      send_item(FUNC_CLASSIFY, 6'd42, 16'sd100, -16'sd100);
      send_item(FUNC_CLASSIFY, 6'd0,  16'sd50, -16'sd50);
      send_item(FUNC_LOAD,     6'd42, -16'sd8000, 16'sd12000);
      send_item(FUNC_CLASSIFY, 6'd0,  -16'sd8001, 16'sd11999);

      for (int n = 0; n < N_RANDOM; n++) begin
         quiet <= (n >= 600 && n < 950);
         random_item();
      end
      req_ch.valid <= 1'b0;
      quiet        <= 1'b0;

      while (sb.expected_crystals.size() != 0) @(posedge clock);
      repeat (PEAKS + 40) @(posedge clock);

      $display("Sent %0d items: %0d peak loads and %0d classifies", n_sent, sb.n_loads,
               sb.n_found + sb.n_range + sb.n_none);
      $display("Classifies: %0d matched a peak, %0d out of range, %0d with empty table",
               sb.n_found, sb.n_range, sb.n_none);
      if (sb.mismatches == 0 && sb.expected_crystals.size() == 0) begin
         $display("PASS nearest_peak_crystal_lookup");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.mismatches,
                  sb.expected_crystals.size());
         $display("FAIL nearest_peak_crystal_lookup");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/npcl_pkg.sv
rtl/npcl_if.sv
rtl/npcl_ram.sv
rtl/nearest_peak_crystal_lookup.sv
dv/testbench.sv
